// ===== hw/rtl/fifo_stereo_level_meter_macros.svh =====
// Assertion helpers shared by the level meter.
`ifndef FIFO_STEREO_LEVEL_METER_MACROS_SVH
`define FIFO_STEREO_LEVEL_METER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fsl_pkg.sv =====
package fsl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int SUM_W       = 36;
    localparam int LEVEL_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int MIN_LEN     = 4;

    localparam logic [17:0]        KNEE_LOW  = 18'h08000;
    localparam logic [17:0]        KNEE_MID  = 18'h0b000;
    localparam logic [17:0]        KNEE_HIGH = 18'h0e000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hffff;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic pop;
        logic idle;
    } back_stat_t;

    function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {1'b0, v};
        if (v[SAMPLE_W-1]) begin
            return (MAG_W'(1) << SAMPLE_W) - ext;
        end
        return ext;
    endfunction

    // Saturate the quotient, then apply the three-knee curve.
    function automatic logic [LEVEL_W-1:0] compress(input logic [SUM_W-1:0] q);
        logic [LEVEL_W-1:0] sat;
        logic [17:0]        t;
        sat = (|q[SUM_W-1:LEVEL_W]) ? LEVEL_MAX : q[LEVEL_W-1:0];
        t = {1'b0, sat, 1'b0};
        if (t > KNEE_LOW) begin
            t = (KNEE_LOW + t) >> 1;
        end
        if (t > KNEE_MID) begin
            t = (KNEE_MID + t) >> 1;
        end
        if (t > KNEE_HIGH) begin
            t = (KNEE_HIGH + t) >> 1;
        end
        return (t > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : t[LEVEL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/fsl_front.sv =====
module fsl_front
    import fsl_pkg::*;
#(
    parameter int QUEUE_LENGTH_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [SAMPLE_W-1:0]          left_sample,
    input  logic [SAMPLE_W-1:0]          right_sample,
    input  logic                         last,
    input  logic [QUEUE_LENGTH_BITS-1:0] queued_length,
    input  q_stat_t                      q_stat,
    output logic                         push,
    output logic                         short_len,
    output logic [QUEUE_LENGTH_BITS-3:0] divisor,
    output logic [SUM_W-1:0]             left_sum,
    output logic [SUM_W-1:0]             right_sum
);

    logic [SUM_W-1:0] left_sum_reg, left_sum_next;
    logic [SUM_W-1:0] right_sum_reg, right_sum_next;
    logic [SUM_W-1:0] left_mag, right_mag;
    logic             accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    assign left_mag  = SUM_W'(sample_mag(left_sample));
    assign right_mag = SUM_W'(sample_mag(right_sample));

    always_comb begin
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        if (accept) begin
            if (operation == OP_PULL) begin
                left_sum_next  = left_sum_reg - left_mag;
                right_sum_next = right_sum_reg - right_mag;
            end else begin
                left_sum_next  = left_sum_reg + left_mag;
                right_sum_next = right_sum_reg + right_mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
        end else begin
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
        end
    end

    // Classify the buffer end: snapshot the updated sums with its divisor.
    assign push      = accept && last;
    assign short_len = queued_length < QUEUE_LENGTH_BITS'(MIN_LEN);
    assign divisor   = queued_length[QUEUE_LENGTH_BITS-1:2];
    assign left_sum  = left_sum_next;
    assign right_sum = right_sum_next;

endmodule

// ===== hw/rtl/fsl_queue.sv =====
module fsl_queue
    import fsl_pkg::*;
#(
    parameter int WIDTH = 91
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output q_stat_t          q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/fsl_div.sv =====
module fsl_div
    import fsl_pkg::*;
#(
    parameter int DIVISOR_W = 18
) (
    input  logic                 aclk,
    input  lane_ctrl_t           ctrl,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [SUM_W-1:0]     quotient
);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W:0]   shifted, diff;
    logic                 fits;

    // Shift-subtract: one quotient bit per step, dividend bits shift out the top.
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctrl.load) begin
            rem_next = '0;
            quo_next = dividend;
        end else if (ctrl.step) begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctrl.load) begin
            div_reg <= divisor;
        end
    end

    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/fsl_back.sv =====
module fsl_back
    import fsl_pkg::*;
#(
    parameter int DIVISOR_W = 18
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  q_stat_t                q_stat,
    input  logic                   short_len,
    input  logic [DIVISOR_W-1:0]   divisor,
    input  logic [SUM_W-1:0]       left_sum,
    input  logic [SUM_W-1:0]       right_sum,
    output back_stat_t             back_stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LEVEL_W-1:0]     left_level,
    output logic [LEVEL_W-1:0]     right_level
);

    localparam int CNT_W = $clog2(SUM_W);

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] left_level_reg, right_level_reg;
    logic               load_out, out_free, pop;
    lane_ctrl_t         lane_ctrl;
    logic [SUM_W-1:0]   left_quo, right_quo;
    logic [SUM_W-1:0]   left_dividend, right_dividend;

    assign out_free = !out_valid_reg || out_ready;

    // A short queue loads zero, so both quotients come out zero at once.
    assign left_dividend  = short_len ? '0 : left_sum;
    assign right_dividend = short_len ? '0 : right_sum;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        lane_ctrl      = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop            = 1'b1;
                    lane_ctrl.load = 1'b1;
                    count_next     = CNT_W'(SUM_W - 1);
                    state_next     = short_len ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                lane_ctrl.step = 1'b1;
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            left_level_reg  <= compress(left_quo);
            right_level_reg <= compress(right_quo);
        end
    end

    fsl_div #(.DIVISOR_W(DIVISOR_W)) u_div_left (
        .aclk     (aclk),
        .ctrl     (lane_ctrl),
        .dividend (left_dividend),
        .divisor  (divisor),
        .quotient (left_quo)
    );

    fsl_div #(.DIVISOR_W(DIVISOR_W)) u_div_right (
        .aclk     (aclk),
        .ctrl     (lane_ctrl),
        .dividend (right_dividend),
        .divisor  (divisor),
        .quotient (right_quo)
    );

    assign back_stat.pop  = pop;
    assign back_stat.idle = state_reg == ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign left_level     = left_level_reg;
    assign right_level    = right_level_reg;

endmodule

// ===== hw/rtl/fifo_stereo_level_meter.sv =====
// Channel  Dir  tdata (low bit up)                               tuser      tlast
// s_       in   left_sample, right_sample, queued_length, pad    operation  last
// m_       out  left_level, right_level                          -          -
//
// A frame is taken every cycle while the buffer-end queue (two entries) has room.
// A frame marked last gives its levels after it is popped into the dividers, runs
// 36 steps of the shift-subtract divider (one per sum bit) and has the curve applied.
// A short queue skips the divider steps.
// Reset clears the running sums, the queue and the output at once.
// An unread result stalls the divider only; frames keep flowing until the queue fills.
`include "fifo_stereo_level_meter_macros.svh"

module fifo_stereo_level_meter
    import fsl_pkg::*;
#(
    parameter int QUEUE_LENGTH_BITS = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // left_sample, right_sample, queued_length, zero pad
    input  logic [((2*SAMPLE_W+QUEUE_LENGTH_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic s_tuser,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // left_level, right_level
    output logic [2*LEVEL_W-1:0] m_tdata
);

    localparam int DIVISOR_W = QUEUE_LENGTH_BITS - 2;
    localparam int ENTRY_W   = 2*SUM_W + DIVISOR_W + 1;

    q_stat_t              q_stat;
    back_stat_t           back_stat;
    logic                 push, short_len;
    logic [DIVISOR_W-1:0] divisor;
    logic [SUM_W-1:0]     left_sum, right_sum;
    logic [ENTRY_W-1:0]   wr_entry, rd_entry;

    fsl_front #(.QUEUE_LENGTH_BITS(QUEUE_LENGTH_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .operation     (s_tuser),
        .left_sample   (s_tdata[SAMPLE_W-1:0]),
        .right_sample  (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .last          (s_tlast),
        .queued_length (s_tdata[2*SAMPLE_W+QUEUE_LENGTH_BITS-1:2*SAMPLE_W]),
        .q_stat        (q_stat),
        .push          (push),
        .short_len     (short_len),
        .divisor       (divisor),
        .left_sum      (left_sum),
        .right_sum     (right_sum)
    );

    assign wr_entry = {short_len, divisor, right_sum, left_sum};

    fsl_queue #(.WIDTH(ENTRY_W)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (back_stat.pop),
        .rd_data (rd_entry),
        .q_stat  (q_stat)
    );

    fsl_back #(.DIVISOR_W(DIVISOR_W)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_stat      (q_stat),
        .short_len   (rd_entry[ENTRY_W-1]),
        .divisor     (rd_entry[ENTRY_W-2:2*SUM_W]),
        .left_sum    (rd_entry[SUM_W-1:0]),
        .right_sum   (rd_entry[2*SUM_W-1:SUM_W]),
        .back_stat   (back_stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .left_level  (m_tdata[LEVEL_W-1:0]),
        .right_level (m_tdata[2*LEVEL_W-1:LEVEL_W])
    );

    `FSL_ASSERT_IMPL(a_push_has_room, aclk, aresetn, push, !q_stat.full, "push into full queue")
    `FSL_ASSERT_IMPL(a_pop_has_entry, aclk, aresetn, back_stat.pop, !q_stat.empty, "pop from empty queue")
    `FSL_ASSERT_NEXT(a_pop_starts_work, aclk, aresetn, back_stat.pop, !back_stat.idle, "pop left back idle")
    `FSL_ASSERT_IMPL(a_result_needs_work, aclk, aresetn, m_tvalid && !$past(m_tvalid) && $past(aresetn), $past(!back_stat.idle), "result without buffer")

endmodule
